/* src/ptw_pkg.sv */
package ptw_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int OFF_W             = 12;
    localparam int FRAME_W           = 64 - OFF_W;
    localparam int BASE_W            = 52 - OFF_W;

    // request kinds
    localparam logic [1:0] REQ_MAP       = 2'd0;
    localparam logic [1:0] REQ_UNMAP     = 2'd1;
    localparam logic [1:0] REQ_TRANSLATE = 2'd2;
    localparam logic [1:0] REQ_NONE      = 2'd3;

    // result status
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_UNMAPPED  = 2'd1;
    localparam logic [1:0] ST_NO_TABLES = 2'd2;
    localparam logic [1:0] ST_DISABLED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_TABLE_BASE = 2'd1;

    // entry flag bits
    localparam int         ENT_PRESENT = 0;
    localparam logic [1:0] ENT_FLAGS   = 2'b11;  // present and writable

    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] vaddr;
        logic [63:0] paddr;
    } t_ptw_req;

    typedef struct packed {
        logic [63:0] phys_addr;
        logic [1:0]  status;
    } t_ptw_rsp;

    typedef struct packed {
        logic              enabled;
        logic [BASE_W-1:0] base_hi;  // table_base bits 51:12
    } t_ptw_cfg;

endpackage

/* src/ptw_table_mem.sv */
module ptw_table_mem #(
    parameter int TABLES = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(TABLES)+ptw_pkg::IDX_W-1:0] i_waddr,
    input  logic [63:0]                              i_wdata,
    input  logic [$clog2(TABLES)+ptw_pkg::IDX_W-1:0] i_raddr,
    output logic [63:0]                              o_rdata
);
    import ptw_pkg::*;

    localparam int DEPTH = TABLES * ENTRIES_PER_TABLE;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ptw_link_unit.sv */
module ptw_link_unit #(
    parameter int TABLES = 64
) (
    input  logic [ptw_pkg::FRAME_W-1:0] i_entry_hi,
    input  logic [ptw_pkg::BASE_W-1:0]  i_base_hi,
    output logic [$clog2(TABLES)-1:0]   o_table,
    output logic                        o_in_pool
);
    import ptw_pkg::*;

    localparam int TW = $clog2(TABLES);

    logic [FRAME_W-1:0] diff;

    // frame distance from the pool base, modulo 2^52 like the 64-bit address math
    assign diff      = i_entry_hi - {{(FRAME_W-BASE_W){1'b0}}, i_base_hi};
    assign o_in_pool = diff < FRAME_W'(TABLES);
    assign o_table   = diff[TW-1:0];

endmodule

/* src/ptw_ctrl.sv */
module ptw_ctrl #(
    parameter int TABLES = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  ptw_pkg::t_ptw_cfg                        i_cfg,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  ptw_pkg::t_ptw_req                        i_in,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output ptw_pkg::t_ptw_rsp                        o_out,
    output logic                                     o_mem_we,
    output logic [$clog2(TABLES)+ptw_pkg::IDX_W-1:0] o_mem_waddr,
    output logic [63:0]                              o_mem_wdata,
    output logic [$clog2(TABLES)+ptw_pkg::IDX_W-1:0] o_mem_raddr,
    input  logic [63:0]                              i_mem_rdata
);
    import ptw_pkg::*;

    localparam int TW = $clog2(TABLES);
    localparam int NW = $clog2(TABLES + 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [NW-1:0]      r_nft, n_nft;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_req, n_req;
    logic [47:0]        r_va, n_va;
    logic [FRAME_W-1:0] r_pa_hi, n_pa_hi;
    logic [1:0]         r_lvl, n_lvl;
    logic [TW-1:0]      r_tbl, n_tbl;
    logic [TW-1:0]      r_clr_tbl, n_clr_tbl;
    t_ptw_rsp           r_rsp, n_rsp;

    logic [IDX_W-1:0]   idx;
    logic [TW-1:0]      link_tbl;
    logic               link_ok;
    logic [FRAME_W-1:0] new_link_hi;

    ptw_link_unit #(
        .TABLES(TABLES)
    ) u_link (
        .i_entry_hi(i_mem_rdata[63:OFF_W]),
        .i_base_hi (i_cfg.base_hi),
        .o_table   (link_tbl),
        .o_in_pool (link_ok)
    );

    always_comb begin
        unique case (r_lvl)
            2'd0:    idx = r_va[47:39];
            2'd1:    idx = r_va[38:30];
            2'd2:    idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    assign new_link_hi = {{(FRAME_W-BASE_W){1'b0}}, i_cfg.base_hi} + FRAME_W'(r_nft);

    always_comb begin
        n_state     = r_state;
        n_nft       = r_nft;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_va        = r_va;
        n_pa_hi     = r_pa_hi;
        n_lvl       = r_lvl;
        n_tbl       = r_tbl;
        n_clr_tbl   = r_clr_tbl;
        n_rsp       = r_rsp;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_tbl, idx};
        o_mem_wdata = '0;
        o_mem_raddr = {r_tbl, idx};

        unique case (r_state)
            S_INIT: begin
                // clear the root table after reset
                o_mem_we    = 1'b1;
                o_mem_waddr = {{TW{1'b0}}, r_cnt};
                n_cnt       = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_in.req_type;
                    n_va    = i_in.vaddr;
                    n_pa_hi = i_in.paddr[63:OFF_W];
                    n_lvl   = '0;
                    n_tbl   = '0;
                    n_rsp   = '{phys_addr: '0, status: ST_DONE};
                    if (!i_cfg.enabled) begin
                        n_rsp.status = ST_DISABLED;
                        n_state      = S_RESP;
                    end else if (i_in.req_type == REQ_NONE) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_lvl != LVL_LEAF) begin
                    if (i_mem_rdata[ENT_PRESENT]) begin
                        if (link_ok) begin
                            n_tbl   = link_tbl;
                            n_lvl   = r_lvl + 1'b1;
                            n_state = S_READ;
                        end else begin
                            n_rsp.status = ST_UNMAPPED;
                            n_state      = S_RESP;
                        end
                    end else if (r_req != REQ_MAP) begin
                        n_rsp.status = ST_UNMAPPED;
                        n_state      = S_RESP;
                    end else if (r_nft >= NW'(TABLES)) begin
                        n_rsp.status = ST_NO_TABLES;
                        n_state      = S_RESP;
                    end else begin
                        // link a fresh table, then clear it
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {new_link_hi, {(OFF_W-2){1'b0}}, ENT_FLAGS};
                        n_clr_tbl   = r_nft[TW-1:0];
                        n_nft       = r_nft + 1'b1;
                        n_cnt       = '0;
                        n_state     = S_CLEAR;
                    end
                end else begin
                    n_state = S_RESP;
                    if (r_req == REQ_MAP) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {r_pa_hi, {(OFF_W-2){1'b0}}, ENT_FLAGS};
                    end else if (!i_mem_rdata[ENT_PRESENT]) begin
                        n_rsp.status = ST_UNMAPPED;
                    end else if (r_req == REQ_UNMAP) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {i_mem_rdata[63:1], 1'b0};
                    end else begin
                        n_rsp.phys_addr = {i_mem_rdata[63:OFF_W], r_va[OFF_W-1:0]};
                    end
                end
            end
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = {r_clr_tbl, r_cnt};
                n_cnt       = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_tbl   = r_clr_tbl;
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_READ;
                end
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_nft   <= NW'(1);
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_nft   <= n_nft;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_va      <= n_va;
        r_pa_hi   <= n_pa_hi;
        r_lvl     <= n_lvl;
        r_tbl     <= n_tbl;
        r_clr_tbl <= n_clr_tbl;
        r_rsp     <= n_rsp;
    end

    assign o_out = r_rsp;

endmodule

/* src/four_level_page_table_walker.sv */
// Four-level page table walker over a local pool of TABLES tables of 512 64-bit
// entries (table 0 is the root). After reset the block clears the root table
// and holds o_in_ready low meanwhile; configuration writes are taken at any
// time. A request is then handled one at a time by a sequencer around a table
// memory with one write port and a registered read port: each level is a read,
// then a check. Map also clears each table it creates, one entry per cycle
// through the same write port. Requests with paging disabled or of unknown
// kind skip the walk and go straight to the result. The result stays on o_out
// until transferred.
module four_level_page_table_walker #(
    parameter int TABLES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptw_pkg::t_ptw_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ptw_pkg::t_ptw_rsp o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [51:0]       i_cfg_data
);
    import ptw_pkg::*;

    localparam int AW = $clog2(TABLES) + IDX_W;

    t_ptw_cfg    r_cfg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [63:0] mem_wdata;
    logic [63:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLED) begin
                r_cfg.enabled <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_TABLE_BASE) begin
                r_cfg.base_hi <= i_cfg_data[51:OFF_W];
            end
        end
    end

    ptw_ctrl #(
        .TABLES(TABLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

    ptw_table_mem #(
        .TABLES(TABLES)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

/* src/ptw_checker.sv */
module ptw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input ptw_pkg::t_ptw_req i_in,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input ptw_pkg::t_ptw_rsp o_out
);
    import ptw_pkg::*;

    // held result must not change before its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // one request at a time: no intake while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("took a request while busy");

    // only a successful walk carries an address
    a_addr_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_DONE |-> o_out.phys_addr == '0)
        else $error("address on failed request");

    // root clear runs right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block active right after reset");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
